FILE: design/nfba_pkg.sv
// Shared types and codes for the next-fit block allocator.
// Used by nfba_ctrl, nfba_dpath and the top level; depends on nothing.
package nfba_pkg;

  localparam int IN_W  = 72;   // func, req_size, req_addr, padded to bytes
  localparam int OUT_W = 104;  // result_addr, status, copy_source, copy_bytes, padded

  localparam logic [1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [1:0] FUNC_FREE    = 2'd1;
  localparam logic [1:0] FUNC_REALLOC = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ZERO    = 3'd1;
  localparam logic [2:0] ST_OOM     = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  localparam logic REG_HEAP_BASE  = 1'b0;
  localparam logic REG_HEAP_LIMIT = 1'b1;

  localparam logic [31:0] HEAP_BASE_RST  = 32'h0010_0000;
  localparam logic [31:0] HEAP_LIMIT_RST = 32'h0100_0000;

  localparam logic [32:0] RND_ADD  = 33'd15;
  localparam logic [32:0] RND_MASK = ~33'd15;

  typedef struct packed {
    logic        is_free;
    logic [31:0] nbytes;
    logic [31:0] offset;
  } entry_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SET_ZERO, OP_SET_UNK, OP_SET_OOM, OP_SET_FULL,
    OP_FIND_INIT, OP_FIND_NEXT, OP_TAKE, OP_MARK_FREE,
    OP_AL_INIT, OP_AL_NEXT, OP_AL_TAKE, OP_BUMP_SUM, OP_BUMP_NEW, OP_AL_FIN,
    OP_SP_INIT, OP_SP_MOVE, OP_SP_FIN, OP_SP_WRI,
    OP_PTR_NEXT, OP_ABSORB, OP_MG_MOVE, OP_MG_END,
    OP_GROW_ON, OP_MOVE_START, OP_INPLACE, OP_AL_END, OP_MOVE_FIND, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       size_zero;
    logic       addr_zero;
    logic       k_end;
    logic       match;
    logic       fits;
    logic       ent_fits;
    logic       has_next;
    logic       next_free;
    logic       ptr_lt_count;
    logic       ptr_at_next;
    logic       split_ok;
    logic       oom;
    logic       full;
    logic       in_alloc;
    logic       moving;
    logic       grow;
    logic       res_ok;
    logic       out_free;
  } stat_t;

endpackage

FILE: design/nfba_ctrl.sv
// Sequencer for the allocator: one-hot state machine issuing datapath ops.
// Depends on nfba_pkg.
module nfba_ctrl
  import nfba_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [26:0] {
    S_IDLE     = 27'(1) << 0,
    S_DISPATCH = 27'(1) << 1,
    S_FIND_WAIT= 27'(1) << 2,
    S_FIND_CHK = 27'(1) << 3,
    S_FOUND    = 27'(1) << 4,
    S_RA_FIT   = 27'(1) << 5,
    S_AL_START = 27'(1) << 6,
    S_AL_WAIT  = 27'(1) << 7,
    S_AL_CHK   = 27'(1) << 8,
    S_BUMP1    = 27'(1) << 9,
    S_BUMP2    = 27'(1) << 10,
    S_AL_RET   = 27'(1) << 11,
    S_SP_CHK   = 27'(1) << 12,
    S_SP_WAIT  = 27'(1) << 13,
    S_SP_MOVE  = 27'(1) << 14,
    S_SP_FIN   = 27'(1) << 15,
    S_SP_WRI   = 27'(1) << 16,
    S_SP_RET   = 27'(1) << 17,
    S_MG_CHK   = 27'(1) << 18,
    S_MG_WAIT  = 27'(1) << 19,
    S_MG_TEST  = 27'(1) << 20,
    S_MG_SHCHK = 27'(1) << 21,
    S_MG_SHMOV = 27'(1) << 22,
    S_MG_END   = 27'(1) << 23,
    S_MG_GROW  = 27'(1) << 24,
    S_MG_EXIT  = 27'(1) << 25,
    S_DONE     = 27'(1) << 26
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.func == FUNC_ALLOC) begin
          state_next = S_AL_START;
        end else if (stat.func == FUNC_FREE || stat.func == FUNC_REALLOC) begin
          if (stat.addr_zero) begin
            state_next = (stat.func == FUNC_FREE) ? S_DONE : S_AL_START;
          end else begin
            cmd.op     = OP_FIND_INIT;
            state_next = S_FIND_WAIT;
          end
        end else begin
          state_next = S_DONE;
        end
      end
      S_FIND_WAIT: state_next = S_FIND_CHK;
      S_FIND_CHK: begin
        if (stat.k_end) begin
          if (!stat.moving) cmd.op = OP_SET_UNK;
          state_next = S_DONE;
        end else if (stat.match) begin
          cmd.op     = OP_TAKE;
          state_next = S_FOUND;
        end else begin
          cmd.op     = OP_FIND_NEXT;
          state_next = S_FIND_WAIT;
        end
      end
      S_FOUND: begin
        if (stat.func == FUNC_FREE || stat.moving || stat.size_zero) begin
          cmd.op     = OP_MARK_FREE;
          state_next = S_MG_CHK;
        end else begin
          state_next = S_RA_FIT;
        end
      end
      S_RA_FIT: begin
        if (stat.ent_fits) begin
          state_next = S_SP_CHK;
        end else begin
          cmd.op     = OP_GROW_ON;
          state_next = S_MG_CHK;
        end
      end
      S_AL_START: begin
        if (stat.size_zero) begin
          cmd.op     = OP_SET_ZERO;
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_AL_INIT;
          state_next = S_AL_WAIT;
        end
      end
      S_AL_WAIT: state_next = S_AL_CHK;
      S_AL_CHK: begin
        if (stat.k_end) begin
          state_next = S_BUMP1;
        end else if (stat.fits) begin
          cmd.op     = OP_AL_TAKE;
          state_next = S_SP_CHK;
        end else begin
          cmd.op     = OP_AL_NEXT;
          state_next = S_AL_WAIT;
        end
      end
      S_BUMP1: begin
        cmd.op     = OP_BUMP_SUM;
        state_next = S_BUMP2;
      end
      S_BUMP2: begin
        if (stat.oom)       cmd.op = OP_SET_OOM;
        else if (stat.full) cmd.op = OP_SET_FULL;
        else                cmd.op = OP_BUMP_NEW;
        state_next = S_AL_RET;
      end
      S_AL_RET: begin
        if (stat.moving && stat.res_ok) begin
          cmd.op     = OP_MOVE_FIND;
          state_next = S_FIND_WAIT;
        end else begin
          cmd.op     = OP_AL_END;
          state_next = S_DONE;
        end
      end
      S_SP_CHK: begin
        if (!stat.split_ok) begin
          state_next = S_SP_RET;
        end else if (stat.has_next) begin
          cmd.op     = OP_SP_INIT;
          state_next = S_SP_WAIT;
        end else begin
          state_next = S_SP_FIN;
        end
      end
      S_SP_WAIT: state_next = S_SP_MOVE;
      S_SP_MOVE: begin
        cmd.op     = OP_SP_MOVE;
        state_next = stat.ptr_at_next ? S_SP_FIN : S_SP_WAIT;
      end
      S_SP_FIN: begin
        cmd.op     = OP_SP_FIN;
        state_next = S_SP_WRI;
      end
      S_SP_WRI: begin
        cmd.op     = OP_SP_WRI;
        state_next = S_SP_RET;
      end
      S_SP_RET: begin
        if (stat.in_alloc) begin
          cmd.op     = OP_AL_FIN;
          state_next = S_AL_RET;
        end else begin
          cmd.op     = OP_INPLACE;
          state_next = S_DONE;
        end
      end
      S_MG_CHK: begin
        if (stat.has_next) begin
          cmd.op     = OP_PTR_NEXT;
          state_next = S_MG_WAIT;
        end else begin
          state_next = S_MG_EXIT;
        end
      end
      S_MG_WAIT: state_next = S_MG_TEST;
      S_MG_TEST: begin
        if (stat.next_free) begin
          cmd.op     = OP_ABSORB;
          state_next = S_MG_SHCHK;
        end else begin
          state_next = S_MG_EXIT;
        end
      end
      S_MG_SHCHK: state_next = stat.ptr_lt_count ? S_MG_SHMOV : S_MG_END;
      S_MG_SHMOV: begin
        cmd.op     = OP_MG_MOVE;
        state_next = S_MG_SHCHK;
      end
      S_MG_END: begin
        cmd.op     = OP_MG_END;
        state_next = stat.grow ? S_MG_GROW : S_MG_CHK;
      end
      S_MG_GROW: state_next = stat.ent_fits ? S_SP_CHK : S_MG_CHK;
      S_MG_EXIT: begin
        if (stat.grow) begin
          cmd.op     = OP_MOVE_START;
          state_next = S_AL_START;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: design/nfba_dpath.sv
// Allocator datapath: block table memory, heap registers and result stage.
// Depends on nfba_pkg; driven op by op from nfba_ctrl.
module nfba_dpath
  import nfba_pkg::*;
#(
  parameter int MAX_BLOCKS   = 256,
  parameter int HEADER_BYTES = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [31:0]      cfg_data,
  input  logic [IN_W-1:0]  in_data,
  output logic [OUT_W-1:0] out_data,
  output logic             out_valid,
  input  logic             out_ready,
  input  cmd_t             cmd,
  output stat_t            stat
);

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [CW-1:0] NO_CUR    = CW'(MAX_BLOCKS);
  localparam logic [CW-1:0] ONE       = CW'(1);
  localparam logic [31:0]   HDR       = 32'(HEADER_BYTES);
  localparam logic [31:0]   SPLIT_MIN = 32'(HEADER_BYTES + 16);

  entry_t mem [MAX_BLOCKS];
  entry_t rd_q;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  entry_t          mem_wd;

  logic [31:0]   base, limit, bump;
  logic [CW-1:0] count, cursor, k, ptr;
  logic [AW-1:0] i;
  logic [1:0]    func_r;
  logic [31:0]   size_r, addr_r, old_bytes;
  logic [32:0]   rsize;
  logic [33:0]   bsum;
  entry_t        ent;
  logic [31:0]   res_addr, res_src, res_cnt;
  logic [2:0]    res_status;
  logic          in_alloc, moving, grow;

  logic [CW-1:0] i_plus1, start, ptr_wrap;
  logic [31:0]   rem;

  assign i_plus1  = CW'(i) + ONE;
  assign start    = (cursor < count) ? cursor : '0;
  assign ptr_wrap = (ptr + ONE == count) ? '0 : ptr + ONE;
  assign rem      = ent.nbytes - rsize[31:0];

  always_comb begin
    stat.func         = func_r;
    stat.size_zero    = (size_r == '0);
    stat.addr_zero    = (addr_r == '0);
    stat.k_end        = (k == count);
    stat.match        = (base + rd_q.offset + HDR == addr_r);
    stat.fits         = rd_q.is_free && ({1'b0, rd_q.nbytes} >= rsize);
    stat.ent_fits     = ({1'b0, ent.nbytes} >= rsize);
    stat.has_next     = (i_plus1 < count);
    stat.next_free    = rd_q.is_free;
    stat.ptr_lt_count = (ptr < count);
    stat.ptr_at_next  = (ptr == i_plus1);
    stat.split_ok     = (rem >= SPLIT_MIN) && (count < NO_CUR);
    stat.oom          = (35'(bsum) + 35'(rsize)) > 35'(limit);
    stat.full         = (count >= NO_CUR);
    stat.in_alloc     = in_alloc;
    stat.moving       = moving;
    stat.grow         = grow;
    stat.res_ok       = (res_status == ST_OK);
    stat.out_free     = !out_valid || out_ready;
  end

  // table write port
  always_comb begin
    mem_we = 1'b0;
    mem_wa = i;
    mem_wd = ent;
    unique case (cmd.op)
      OP_MARK_FREE: begin
        mem_we         = 1'b1;
        mem_wd.is_free = 1'b1;
      end
      OP_AL_TAKE: begin
        mem_we         = 1'b1;
        mem_wa         = ptr[AW-1:0];
        mem_wd         = rd_q;
        mem_wd.is_free = 1'b0;
      end
      OP_BUMP_NEW: begin
        mem_we = 1'b1;
        mem_wa = count[AW-1:0];
        mem_wd = '{is_free: 1'b0, nbytes: rsize[31:0], offset: bump};
      end
      OP_SP_MOVE: begin
        mem_we = 1'b1;
        mem_wa = AW'(ptr + ONE);
        mem_wd = rd_q;
      end
      OP_SP_FIN: begin
        mem_we = 1'b1;
        mem_wa = i_plus1[AW-1:0];
        mem_wd = '{is_free: 1'b1, nbytes: rem - HDR,
                   offset: ent.offset + HDR + rsize[31:0]};
      end
      OP_SP_WRI: begin
        mem_we        = 1'b1;
        mem_wd.nbytes = rsize[31:0];
      end
      OP_MG_MOVE: begin
        mem_we = 1'b1;
        mem_wa = AW'(ptr - ONE);
        mem_wd = rd_q;
      end
      OP_MG_END: mem_we = 1'b1;
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[ptr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base      <= HEAP_BASE_RST;
      limit     <= HEAP_LIMIT_RST;
      count     <= '0;
      cursor    <= NO_CUR;
      bump      <= '0;
      in_alloc  <= 1'b0;
      moving    <= 1'b0;
      grow      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_HEAP_BASE) base <= cfg_data;
        else                            limit <= cfg_data;
      end
      if (out_valid && out_ready && cmd.op != OP_EMIT) out_valid <= 1'b0;
      unique case (cmd.op)
        OP_LOAD: begin
          func_r     <= in_data[1:0];
          size_r     <= in_data[33:2];
          addr_r     <= in_data[65:34];
          rsize      <= ({1'b0, in_data[33:2]} + RND_ADD) & RND_MASK;
          res_addr   <= '0;
          res_status <= ST_OK;
          res_src    <= '0;
          res_cnt    <= '0;
          in_alloc   <= 1'b0;
          moving     <= 1'b0;
          grow       <= 1'b0;
        end
        OP_SET_ZERO: res_status <= ST_ZERO;
        OP_SET_UNK:  res_status <= ST_UNKNOWN;
        OP_SET_OOM:  res_status <= ST_OOM;
        OP_SET_FULL: res_status <= ST_FULL;
        OP_FIND_INIT: begin
          k   <= '0;
          ptr <= '0;
        end
        OP_FIND_NEXT: begin
          k   <= k + ONE;
          ptr <= ptr + ONE;
        end
        OP_TAKE: begin
          i   <= ptr[AW-1:0];
          ent <= rd_q;
        end
        OP_MARK_FREE: begin
          ent.is_free <= 1'b1;
          if (func_r == FUNC_REALLOC && size_r == '0) res_status <= ST_ZERO;
        end
        OP_AL_INIT: begin
          k        <= '0;
          ptr      <= start;
          in_alloc <= 1'b1;
        end
        OP_AL_NEXT: begin
          k   <= k + ONE;
          ptr <= ptr_wrap;
        end
        OP_AL_TAKE: begin
          i   <= ptr[AW-1:0];
          ent <= '{is_free: 1'b0, nbytes: rd_q.nbytes, offset: rd_q.offset};
        end
        OP_BUMP_SUM: bsum <= 34'(base) + 34'(bump) + 34'(HDR);
        OP_BUMP_NEW: begin
          count    <= count + ONE;
          bump     <= bump + HDR + rsize[31:0];
          res_addr <= bsum[31:0];
        end
        OP_AL_FIN: begin
          cursor   <= (i_plus1 < count) ? i_plus1 : NO_CUR;
          res_addr <= base + ent.offset + HDR;
        end
        OP_SP_INIT: ptr <= count - ONE;
        OP_SP_MOVE: ptr <= ptr - ONE;
        OP_SP_FIN: begin
          count <= count + ONE;
          if (cursor > CW'(i) && cursor != NO_CUR) cursor <= cursor + ONE;
        end
        OP_SP_WRI: ent.nbytes <= rsize[31:0];
        OP_PTR_NEXT: ptr <= i_plus1;
        OP_ABSORB: begin
          ent.nbytes <= ent.nbytes + HDR + rd_q.nbytes;
          ptr        <= i_plus1 + ONE;
        end
        OP_MG_MOVE: ptr <= ptr + ONE;
        OP_MG_END: begin
          count <= count - ONE;
          if (cursor == i_plus1)                          cursor <= CW'(i);
          else if (cursor > i_plus1 && cursor != NO_CUR) cursor <= cursor - ONE;
        end
        OP_GROW_ON: grow <= 1'b1;
        OP_MOVE_START: begin
          old_bytes <= ent.nbytes;
          moving    <= 1'b1;
          grow      <= 1'b0;
        end
        OP_INPLACE: res_addr <= addr_r;
        OP_AL_END:  in_alloc <= 1'b0;
        OP_MOVE_FIND: begin
          in_alloc <= 1'b0;
          res_src  <= addr_r;
          res_cnt  <= old_bytes;
          k        <= '0;
          ptr      <= '0;
        end
        OP_EMIT: begin
          out_data  <= {5'b0, res_cnt, res_src, res_status, res_addr};
          out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: design/next_fit_block_allocator.sv
// Next-fit block allocator: one request beat in, one result beat out.
// Lookup, search, split and merge each walk or shift table entries, so a request takes
// longer as the table fills; a merge shifts every tail entry down once per absorbed block.
// Throughput: one request at a time; the block table has one write port and one
// registered read port.
// Reset (rst, synchronous): empty table, no cursor, bump at 0, default base/limit.
module next_fit_block_allocator
  import nfba_pkg::*;
#(
  parameter int MAX_BLOCKS   = 256,
  parameter int HEADER_BYTES = 12
) (
  input  logic             clk,
  input  logic             rst,
  // config: index 0 heap_base, 1 heap_limit
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [31:0]      cfg_data,
  // request beat
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,  // func[1:0], req_size[33:2], req_addr[65:34]
  // result beat
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata   // result_addr[31:0], status[34:32],
                                          // copy_source[66:35], copy_bytes[98:67]
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer: walks the table one entry at a time, waiting on each registered read; issues at most one op per cycle.
  nfba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: table memory, cursor/count/bump, result register (frees the
  // sequencer while a finished result waits downstream).
  nfba_dpath #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .out_data  (m_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

`ifndef ASSERT_OFF
  // a request beat starts work, so the input closes at once
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input still open after accepting a request");

  // failed requests never hand out an address
  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[34:32] != ST_OK) |-> (m_axis_tdata[31:0] == '0))
    else $error("address given out with a failure status");

  // a copy is only reported by a successful moving reallocate
  a_copy_ok: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[98:67] != '0) |-> (m_axis_tdata[34:32] == ST_OK))
    else $error("copy range reported on a failed request");

  // an emit always lands in the result register
  a_emit: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_EMIT) |=> m_axis_tvalid)
    else $error("result emitted but no beat presented");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for next_fit_block_allocator: request stream in, result stream out.
// Predicts every result from its own copy of the block table; depends on nfba_pkg and the RTL.
module tb
  import nfba_pkg::*;
;

  localparam int MAXB = 256;
  localparam int HDR  = 12;
  localparam int SETTLE = 1400;  // quiet cycles between phases

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] size;
    logic [31:0] addr;
  } req_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [2:0]  status;
    logic [31:0] src;
    logic [31:0] cnt;
  } res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_HEAP_BASE;
  logic [31:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;  // func, req_size, req_addr, pad
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;  // result_addr, status, copy_source, copy_bytes, pad

  next_fit_block_allocator dut (.*);

  always #2 clk = ~clk;

  // ---- shadow of the block table ----
  logic [31:0] blk_off [MAXB];
  logic [31:0] blk_len [MAXB];
  logic        blk_free[MAXB];
  int          nblk;
  int          cursor;   // MAXB: no cursor
  logic [31:0] bump;
  logic [31:0] heap_base, heap_limit;

  req_t        pend_reqs[$];   // waiting for the driver
  res_t        exp_results[$]; // predicted, not yet seen
  logic [31:0] live_ptrs[$];   // payload addresses currently handed out
  int          mode;           // 0 none, 1 sender idle, 2 receiver stall, 3 both light
  int          errors = 0;
  logic        req_taken = 1'b0;

  function automatic logic [31:0] payload(int i);
    return heap_base + blk_off[i] + HDR;
  endfunction

  function automatic int lookup(logic [31:0] a);
    for (int i = 0; i < nblk; i++)
      if (payload(i) == a) return i;
    return MAXB;
  endfunction

  function automatic void absorb(int i);
    int j;
    j = i + 1;
    blk_len[i] += HDR + blk_len[j];
    for (int k = j; k < nblk - 1; k++) begin
      blk_off[k] = blk_off[k+1]; blk_len[k] = blk_len[k+1]; blk_free[k] = blk_free[k+1];
    end
    nblk--;
    if (cursor == j) cursor = i;
    else if (cursor > j && cursor != MAXB) cursor--;
  endfunction

  function automatic void coalesce(int i);
    while (i + 1 < nblk && blk_free[i+1]) absorb(i);
  endfunction

  function automatic void carve(int i, logic [31:0] size);
    logic [31:0] rem;
    rem = blk_len[i] - size;
    if (rem < HDR + 16 || nblk >= MAXB) return;
    for (int k = nblk; k > i + 1; k--) begin
      blk_off[k] = blk_off[k-1]; blk_len[k] = blk_len[k-1]; blk_free[k] = blk_free[k-1];
    end
    blk_off[i+1] = blk_off[i] + HDR + size;
    blk_len[i+1] = rem - HDR;
    blk_free[i+1] = 1'b1;
    blk_len[i] = size;
    nblk++;
    if (cursor > i && cursor != MAXB) cursor++;
  endfunction

  function automatic longint rounded(logic [31:0] req);
    return (longint'(req) + 15) & ~longint'(15);
  endfunction

  function automatic logic [2:0] grab(logic [31:0] req, output logic [31:0] a);
    longint size;
    int start, i;
    a = '0;
    if (req == 0) return ST_ZERO;
    size = rounded(req);
    start = (cursor < nblk) ? cursor : 0;
    for (int k = 0; k < nblk; k++) begin
      i = start + k;
      if (i >= nblk) i -= nblk;
      if (blk_free[i] && longint'(blk_len[i]) >= size) begin
        blk_free[i] = 1'b0;
        carve(i, size[31:0]);
        cursor = (i + 1 < nblk) ? i + 1 : MAXB;
        a = payload(i);
        return ST_OK;
      end
    end
    if (longint'(heap_base) + longint'(bump) + HDR + size > longint'(heap_limit)) return ST_OOM;
    if (nblk >= MAXB) return ST_FULL;
    blk_off[nblk] = bump;
    blk_len[nblk] = size[31:0];
    blk_free[nblk] = 1'b0;
    nblk++;
    bump += HDR + size[31:0];
    a = payload(nblk - 1);
    return ST_OK;
  endfunction

  function automatic res_t serve(req_t r);
    res_t o;
    int i;
    longint size;
    logic done;
    logic [31:0] old_len;
    o = '0;
    case (r.func)
      FUNC_ALLOC: o.status = grab(r.size, o.addr);
      FUNC_FREE: if (r.addr != 0) begin
        i = lookup(r.addr);
        if (i == MAXB) o.status = ST_UNKNOWN;
        else begin blk_free[i] = 1'b1; coalesce(i); end
      end
      FUNC_REALLOC: begin
        if (r.addr == 0) o.status = grab(r.size, o.addr);
        else begin
          i = lookup(r.addr);
          if (i == MAXB) o.status = ST_UNKNOWN;
          else if (r.size == 0) begin
            blk_free[i] = 1'b1; coalesce(i); o.status = ST_ZERO;
          end else begin
            size = rounded(r.size);
            done = 1'b0;
            if (longint'(blk_len[i]) >= size) begin carve(i, size[31:0]); done = 1'b1; end
            while (!done && i + 1 < nblk && blk_free[i+1]) begin
              absorb(i);
              if (longint'(blk_len[i]) >= size) begin carve(i, size[31:0]); done = 1'b1; end
            end
            if (done) o.addr = r.addr;
            else begin
              // moving case: new block first, then release the old one
              old_len = blk_len[i];
              o.status = grab(r.size, o.addr);
              if (o.status == ST_OK) begin
                o.src = r.addr;
                o.cnt = old_len;
                i = lookup(r.addr);
                if (i != MAXB) begin blk_free[i] = 1'b1; coalesce(i); end
              end
            end
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic void drop_ptr(logic [31:0] a);
    foreach (live_ptrs[k])
      if (live_ptrs[k] == a) begin live_ptrs.delete(k); return; end
  endfunction

  // keep the pool of handed-out pointers roughly current for stimulus
  function automatic void track(req_t r, res_t o);
    if (r.func == FUNC_FREE && o.status == ST_OK) drop_ptr(r.addr);
    if (r.func == FUNC_REALLOC && o.status == ST_ZERO) drop_ptr(r.addr);
    if (r.func == FUNC_REALLOC && o.src != 0) drop_ptr(r.addr);
    if (o.status == ST_OK && o.addr != 0 && o.addr != r.addr) live_ptrs.push_back(o.addr);
  endfunction

  // ---- driver: next beat at the falling edge ----
  always @(negedge clk) begin
    req_t nx;
    if (!rst) begin
      if (!s_axis_tvalid || req_taken) begin
        if (pend_reqs.size() > 0 &&
            !($urandom_range(0, 99) < (mode == 1 ? 80 : mode == 3 ? 6 : 0))) begin
          nx = pend_reqs.pop_front();
          // func in the lowest bits, then size, then addr
          s_axis_tdata <= {6'b0, nx.addr, nx.size, nx.func};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= !($urandom_range(0, 99) < (mode == 2 ? 80 : mode == 3 ? 6 : 0));
    end
  end

  // ---- monitor: predict on request beat, check on result beat ----
  always @(posedge clk) begin
    req_t r;
    res_t want, got;
    req_taken <= s_axis_tvalid && s_axis_tready && !rst;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      // tdata low bits are func, then size, then addr
      r.func = s_axis_tdata[1:0];
      r.size = s_axis_tdata[33:2];
      r.addr = s_axis_tdata[65:34];
      want = serve(r);
      track(r, want);
      exp_results.push_back(want);
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.addr = m_axis_tdata[31:0];
      got.status = m_axis_tdata[34:32];
      got.src = m_axis_tdata[66:35];
      got.cnt = m_axis_tdata[98:67];
      if (exp_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = exp_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: addr %h/%h status %0d/%0d src %h/%h bytes %h/%h (exp/act)",
                     want.addr, got.addr, want.status, got.status,
                     want.src, got.src, want.cnt, got.cnt);
        end
      end
    end
  end

  task automatic drain();
    wait (pend_reqs.size() == 0 && !s_axis_tvalid && exp_results.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    if (idx == REG_HEAP_BASE) heap_base = val; else heap_limit = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic post(logic [1:0] f, logic [31:0] s, logic [31:0] a);
    req_t r;
    r.func = f; r.size = s; r.addr = a;
    pend_reqs.push_back(r);
  endtask

  function automatic logic [31:0] some_ptr();
    if (live_ptrs.size() == 0) return $urandom;
    return live_ptrs[$urandom_range(0, live_ptrs.size() - 1)];
  endfunction

  task automatic random_run(int count, int alloc_pct);
    int roll;
    logic [31:0] sz, ad;
    for (int n = 0; n < count; n++) begin
      wait (pend_reqs.size() < 2);
      roll = $urandom_range(0, 99);
      case ($urandom_range(0, 19))
        0:       sz = 0;
        1:       sz = $urandom;
        2, 3, 4: sz = $urandom_range(257, 4096);
        default: sz = $urandom_range(1, 256);
      endcase
      case ($urandom_range(0, 19))
        0:       ad = 0;
        1, 2:    ad = $urandom;
        default: ad = some_ptr();
      endcase
      if (roll < alloc_pct) post(FUNC_ALLOC, sz, 32'h0);
      else if (roll < alloc_pct + (95 - alloc_pct) * 3 / 5) post(FUNC_FREE, $urandom, ad);
      else if (roll < 95) post(FUNC_REALLOC, sz, ad);
      else post(2'd3, $urandom, $urandom);
    end
  endtask

  initial begin
    #(200_000_000);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [31:0] p;
    nblk = 0; cursor = MAXB; bump = '0;
    heap_base = HEAP_BASE_RST; heap_limit = HEAP_LIMIT_RST;
    mode = 0;
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    write_reg(REG_HEAP_BASE, HEAP_BASE_RST);
    write_reg(REG_HEAP_LIMIT, HEAP_LIMIT_RST);

    // directed: size extremes, bad pointers, unused func, shrink/grow/move
    post(FUNC_ALLOC, 32'd0, 32'h0);
    post(FUNC_ALLOC, 32'd1, 32'h0);
    post(FUNC_ALLOC, 32'hFFFF_FFFF, 32'h0);     // rounds past 32 bits
    post(FUNC_ALLOC, 32'hFFFF_FFF1, 32'h0);
    post(FUNC_ALLOC, 32'd100, 32'h0);
    post(FUNC_ALLOC, 32'd200, 32'h0);
    post(FUNC_ALLOC, 32'd48, 32'h0);
    post(FUNC_FREE, 32'd0, 32'h0);              // null free
    post(FUNC_FREE, 32'd0, 32'h1234);           // unknown pointer
    post(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    post(FUNC_REALLOC, 32'd40, 32'h0);          // realloc of null = alloc
    drain();
    p = live_ptrs[2];
    post(FUNC_REALLOC, 32'd8, p);               // shrink in place with split
    post(FUNC_REALLOC, 32'd0, live_ptrs[3]);    // zero size frees
    post(FUNC_FREE, 32'd0, live_ptrs[0]);
    post(FUNC_FREE, 32'd0, live_ptrs[0]);       // double free of the same pointer
    post(FUNC_REALLOC, 32'd64, live_ptrs[1]);   // shrink in place with split
    post(FUNC_REALLOC, 32'd5000, p);            // must move
    post(FUNC_REALLOC, 32'd10, 32'h5555_0000);  // unknown pointer
    drain();
    write_reg(REG_HEAP_LIMIT, 32'h0);           // nothing new fits
    post(FUNC_ALLOC, 32'd16, 32'h0);
    post(FUNC_ALLOC, 32'd17, 32'h0);
    drain();
    write_reg(REG_HEAP_LIMIT, HEAP_LIMIT_RST);

    // random phases, each with its own heap window and idling pattern
    random_run(230, 45);
    drain();
    mode = 1;
    write_reg(REG_HEAP_BASE, 32'h0000_4000);
    write_reg(REG_HEAP_LIMIT, 32'h0000_4000 + bump + 32'h2000);  // tight: out of memory often
    random_run(230, 45);
    drain();
    mode = 2;
    write_reg(REG_HEAP_BASE, 32'h0);
    write_reg(REG_HEAP_LIMIT, 32'hFFFF_FFFF);   // widest window, alloc-heavy to fill table
    random_run(230, 75);
    drain();
    mode = 3;
    write_reg(REG_HEAP_BASE, 32'hFFFF_FF00);    // payload addresses wrap
    write_reg(REG_HEAP_LIMIT, 32'hFFFF_FFFF);
    random_run(230, 45);
    drain();

    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
